[hdl/escaped_string_decoder_assert.svh]
// Assertion macros for the escaped string decoder.
// Both macros check on the rising clock edge and are disabled while reset is low.
`ifndef ESCAPED_STRING_DECODER_ASSERT_SVH
`define ESCAPED_STRING_DECODER_ASSERT_SVH
`ifndef SYNTH
// The property must hold at every checked edge.
`define ESD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("escaped_string_decoder assertion failed");
// The condition must never be true.
`define ESD_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("escaped_string_decoder forbidden condition seen");
`else
`define ESD_ASSERT(lbl, clk, rst_n, prop)
`define ESD_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

[hdl/esd_pkg.sv]
`default_nettype none

package esd_pkg;

    // Decoder state
    typedef enum logic [2:0] {
        MODE_PLAIN,
        MODE_ESC,
        MODE_OCT1,
        MODE_OCT2,
        MODE_HEX0,
        MODE_HEX1
    } mode_t;

    // One queued result item
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        end_of_string;
        logic [15:0] decoded_length;
    } res_t;

    // Result queue sizing
    localparam int QDEPTH = 4;
    localparam int QPW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);
    localparam int MAX_RES = 3;

    // Characters
    localparam logic [7:0] CH_BSL = 8'h5C;
    localparam logic [7:0] CH_A   = 8'h61;
    localparam logic [7:0] CH_B   = 8'h62;
    localparam logic [7:0] CH_E   = 8'h65;
    localparam logic [7:0] CH_F   = 8'h66;
    localparam logic [7:0] CH_N   = 8'h6E;
    localparam logic [7:0] CH_R   = 8'h72;
    localparam logic [7:0] CH_T   = 8'h74;
    localparam logic [7:0] CH_V   = 8'h76;
    localparam logic [7:0] CH_X   = 8'h78;

    // Control bytes for the single-letter escapes
    localparam logic [7:0] BY_BEL = 8'h07;
    localparam logic [7:0] BY_BS  = 8'h08;
    localparam logic [7:0] BY_ESC = 8'h1B;
    localparam logic [7:0] BY_FF  = 8'h0C;
    localparam logic [7:0] BY_LF  = 8'h0A;
    localparam logic [7:0] BY_CR  = 8'h0D;
    localparam logic [7:0] BY_TAB = 8'h09;
    localparam logic [7:0] BY_VT  = 8'h0B;
    localparam logic [8:0] OCT_MAX = 9'd255;

    function automatic logic is_oct(input logic [7:0] c);
        return c inside {[8'h30:8'h37]};
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            v = c[3:0];
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            v = 4'(c[3:0] + 4'd9);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

[hdl/escaped_string_decoder.sv]
// Path: input register, then the result queue, whose head drives m_*.
// Throughput: one input item per cycle while results drain at one per cycle;
//   an item yields 0 to 3 results, buffered in a 4-entry result queue that
//   stalls the decode register when it lacks room for the item's results.
// Reset: synchronous, active low; clears decoder mode, held value, byte count
//   and the queue; the decoder starts in plain-text mode.
`default_nettype none
`include "escaped_string_decoder_assert.svh"

module escaped_string_decoder #(
    parameter longint unsigned MAX_STRING_LEN = 65535
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_in_char,
    input  wire logic        s_is_final,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_byte_valid,
    output logic             m_end_of_string,
    output logic [15:0]      m_decoded_length
);
    import esd_pkg::*;

    localparam logic [15:0] CountCap =
        (MAX_STRING_LEN < 65535) ? 16'(MAX_STRING_LEN) : 16'hFFFF;

    // Input register
    logic        in_valid_reg;
    logic [7:0]  in_char_reg;
    logic        in_final_reg;

    // Decoder state
    mode_t       mode_reg, mode_next;
    logic [8:0]  held_reg, held_next;
    logic [15:0] count_reg, count_next;

    // Result queue
    res_t             fifo_reg [QDEPTH];
    logic [QPW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCW-1:0]   cnt_reg, cnt_next;
    logic [QCW-1:0]   free;

    // Decode results
    logic [7:0]  em [MAX_RES];
    logic [1:0]  n_bytes;
    logic [1:0]  push_n;
    logic [16:0] count_sum;
    logic [15:0] count_sat;
    res_t        ent [MAX_RES];
    logic        fire;
    logic        pop;

    // Decode one character against the current mode
    always_comb begin
        logic       do_plain;
        logic [8:0] oct_v;
        logic [7:0] c;
        c         = in_char_reg;
        do_plain  = 1'b0;
        oct_v     = {held_reg[5:0], c[2:0]};
        n_bytes   = 2'd0;
        em        = '{default: 8'd0};
        mode_next = mode_reg;
        held_next = held_reg;

        case (mode_reg)
            MODE_ESC: begin
                mode_next = MODE_PLAIN;
                case (c)
                    CH_A: begin em[n_bytes] = BY_BEL; n_bytes = n_bytes + 2'd1; end
                    CH_B: begin em[n_bytes] = BY_BS;  n_bytes = n_bytes + 2'd1; end
                    CH_E: begin em[n_bytes] = BY_ESC; n_bytes = n_bytes + 2'd1; end
                    CH_F: begin em[n_bytes] = BY_FF;  n_bytes = n_bytes + 2'd1; end
                    CH_N: begin em[n_bytes] = BY_LF;  n_bytes = n_bytes + 2'd1; end
                    CH_R: begin em[n_bytes] = BY_CR;  n_bytes = n_bytes + 2'd1; end
                    CH_T: begin em[n_bytes] = BY_TAB; n_bytes = n_bytes + 2'd1; end
                    CH_V: begin em[n_bytes] = BY_VT;  n_bytes = n_bytes + 2'd1; end
                    CH_X: mode_next = MODE_HEX0;
                    default: begin
                        if (is_oct(c)) begin
                            held_next = {6'd0, c[2:0]};
                            mode_next = MODE_OCT1;
                        end else begin
                            em[n_bytes] = c;
                            n_bytes = n_bytes + 2'd1;
                        end
                    end
                endcase
            end
            MODE_OCT1: begin
                if (is_oct(c)) begin
                    held_next = oct_v;
                    mode_next = MODE_OCT2;
                end else begin
                    em[n_bytes] = held_reg[7:0];
                    n_bytes = n_bytes + 2'd1;
                    do_plain = 1'b1;
                end
            end
            MODE_OCT2: begin
                if (is_oct(c)) begin
                    em[n_bytes] = (oct_v > OCT_MAX) ? 8'hFF : oct_v[7:0];
                    n_bytes = n_bytes + 2'd1;
                    mode_next = MODE_PLAIN;
                end else begin
                    em[n_bytes] = held_reg[7:0];
                    n_bytes = n_bytes + 2'd1;
                    do_plain = 1'b1;
                end
            end
            MODE_HEX0: begin
                if (is_hex(c)) begin
                    held_next = {1'b0, c};
                    mode_next = MODE_HEX1;
                end else begin
                    em[n_bytes] = CH_X;
                    n_bytes = n_bytes + 2'd1;
                    do_plain = 1'b1;
                end
            end
            MODE_HEX1: begin
                if (is_hex(c)) begin
                    em[n_bytes] = {hex_val(held_reg[7:0]), hex_val(c)};
                    n_bytes = n_bytes + 2'd1;
                    mode_next = MODE_PLAIN;
                end else begin
                    em[n_bytes] = CH_X;
                    n_bytes = n_bytes + 2'd1;
                    em[n_bytes] = held_reg[7:0];
                    n_bytes = n_bytes + 2'd1;
                    do_plain = 1'b1;
                end
            end
            default: do_plain = 1'b1;
        endcase

        // Plain text handling; a backslash opens an escape
        if (do_plain) begin
            if (c == CH_BSL) begin
                mode_next = MODE_ESC;
            end else begin
                mode_next = MODE_PLAIN;
                em[n_bytes] = c;
                n_bytes = n_bytes + 2'd1;
            end
        end

        // Flush a pending escape at end of string; a lone backslash is dropped
        if (in_final_reg) begin
            case (mode_next)
                MODE_OCT1, MODE_OCT2: begin
                    em[n_bytes] = held_next[7:0];
                    n_bytes = n_bytes + 2'd1;
                end
                MODE_HEX0: begin
                    em[n_bytes] = CH_X;
                    n_bytes = n_bytes + 2'd1;
                end
                MODE_HEX1: begin
                    em[n_bytes] = CH_X;
                    n_bytes = n_bytes + 2'd1;
                    em[n_bytes] = held_next[7:0];
                    n_bytes = n_bytes + 2'd1;
                end
                default: ;
            endcase
            mode_next = MODE_PLAIN;
            held_next = 9'd0;
        end
    end

    // Saturating byte count
    assign count_sum  = {1'b0, count_reg} + 17'(n_bytes);
    assign count_sat  = (count_sum > {1'b0, CountCap}) ? CountCap : count_sum[15:0];
    assign count_next = in_final_reg ? 16'd0 : count_sat;

    // An end with no byte still yields one empty end-of-string item
    assign push_n = (in_final_reg && (n_bytes == 2'd0)) ? 2'd1 : n_bytes;

    // Build result items
    always_comb begin
        for (int i = 0; i < MAX_RES; i++) begin
            ent[i].out_byte       = em[i];
            ent[i].byte_valid     = (2'(i) < n_bytes);
            ent[i].end_of_string  = in_final_reg && (2'(i) == 2'(push_n - 2'd1));
            ent[i].decoded_length = ent[i].end_of_string ? count_sat : 16'd0;
        end
    end

    // Handshake and queue control
    assign free     = QCW'(QDEPTH) - cnt_reg;
    assign fire     = in_valid_reg && (QCW'(push_n) <= free);
    assign s_ready  = !in_valid_reg || fire;
    assign m_valid  = (cnt_reg != '0);
    assign pop      = m_valid && m_ready;
    assign cnt_next = cnt_reg + (fire ? QCW'(push_n) : QCW'(0)) - (pop ? QCW'(1) : QCW'(0));

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            mode_reg     <= MODE_PLAIN;
            held_reg     <= 9'd0;
            count_reg    <= 16'd0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            cnt_reg      <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (fire) begin
                mode_reg   <= mode_next;
                held_reg   <= held_next;
                count_reg  <= count_next;
                wr_ptr_reg <= QPW'(wr_ptr_reg + QPW'(push_n));
            end
            if (pop) begin
                rd_ptr_reg <= QPW'(rd_ptr_reg + QPW'(1));
            end
            cnt_reg <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg  <= s_in_char;
            in_final_reg <= s_is_final;
        end
        if (fire) begin
            for (int i = 0; i < MAX_RES; i++) begin
                if (2'(i) < push_n) begin
                    fifo_reg[QPW'(wr_ptr_reg + QPW'(i))] <= ent[i];
                end
            end
        end
    end

    // Queue head drives the result channel
    assign m_out_byte       = fifo_reg[rd_ptr_reg].out_byte;
    assign m_byte_valid     = fifo_reg[rd_ptr_reg].byte_valid;
    assign m_end_of_string  = fifo_reg[rd_ptr_reg].end_of_string;
    assign m_decoded_length = fifo_reg[rd_ptr_reg].decoded_length;

    // Checks
    `ESD_NEVER(a_queue_overflow, aclk, aresetn, cnt_reg > QCW'(QDEPTH))
    `ESD_ASSERT(a_final_pushes, aclk, aresetn,
        (fire && in_final_reg) |-> (push_n != 2'd0))
    `ESD_ASSERT(a_final_clears, aclk, aresetn,
        (fire && in_final_reg) |=> (mode_reg == MODE_PLAIN && count_reg == 16'd0))
    `ESD_ASSERT(a_empty_item_is_end, aclk, aresetn,
        (m_valid && !m_byte_valid) |-> (m_end_of_string && m_out_byte == 8'd0))

endmodule

`default_nettype wire

[sim/escaped_string_decoder_tb.sv]
`timescale 1ns / 100ps

module escaped_string_decoder_tb;
    import esd_pkg::*;

    localparam int          STALL_LIMIT  = 5000;
    localparam int          DRAIN_CYCLES = 12;
    localparam int          IDLE_PCT     = 27;
    localparam int          RANDOM_ITEMS = 350;
    localparam int          LONG_ITEMS   = 64;
    localparam logic [15:0] COUNT_CAP    = 16'hFFFF;

    // Digit bounds for the octal and hex escapes
    localparam logic [7:0] DIG_0  = 8'h30;
    localparam logic [7:0] DIG_7  = 8'h37;
    localparam logic [7:0] DIG_9  = 8'h39;
    localparam logic [7:0] UPP_A  = 8'h41;
    localparam logic [7:0] UPP_F  = 8'h46;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_char = 8'h00;
    logic        s_is_final = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_byte_valid;
    logic        m_end_of_string;
    logic [15:0] m_decoded_length;

    // Decoder shadow state
    mode_t       dec_mode = MODE_PLAIN;
    logic [8:0]  dec_held = '0;
    logic [15:0] dec_count = '0;
    res_t        step_res [0:2];
    int          step_n;

    res_t        expected_bytes [$];
    int          fail_count = 0;
    int          stall_cycles = 0;
    bit          no_idle = 1'b0;

    escaped_string_decoder dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_in_char        (s_in_char),
        .s_is_final       (s_is_final),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_byte_valid     (m_byte_valid),
        .m_end_of_string  (m_end_of_string),
        .m_decoded_length (m_decoded_length)
    );

    always #10 aclk = ~aclk;

    function automatic bit is_octal_digit(input logic [7:0] c);
        return (c >= DIG_0) && (c <= DIG_7);
    endfunction

    function automatic bit is_hex_digit(input logic [7:0] c);
        logic [7:0] up;
        up = c & 8'hDF;   // fold lower case onto upper case
        return ((c >= DIG_0) && (c <= DIG_9)) || ((up >= UPP_A) && (up <= UPP_F));
    endfunction

    // Only called with a hex digit; letters have low nibble 1..6
    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        if (c <= DIG_9) begin
            return c[3:0];
        end
        return c[3:0] + 4'd9;
    endfunction

    // One decoded byte: queue it for this item and bump the saturating count
    function automatic void put_byte(input logic [7:0] b);
        if (step_n < MAX_RES) begin
            step_res[step_n].out_byte       = b;
            step_res[step_n].byte_valid     = 1'b1;
            step_res[step_n].end_of_string  = 1'b0;
            step_res[step_n].decoded_length = 16'd0;
            step_n++;
        end
        if (dec_count < COUNT_CAP) begin
            dec_count++;
        end
    endfunction

    function automatic void take_plain(input logic [7:0] c);
        dec_mode = MODE_PLAIN;
        if (c == CH_BSL) begin
            dec_mode = MODE_ESC;
        end else begin
            put_byte(c);
        end
    endfunction

    function automatic void decode_char(input logic [7:0] c);
        logic [11:0] oct;
        case (dec_mode)
            MODE_ESC: begin
                dec_mode = MODE_PLAIN;
                case (c)
                    CH_A: put_byte(BY_BEL);
                    CH_B: put_byte(BY_BS);
                    CH_E: put_byte(BY_ESC);
                    CH_F: put_byte(BY_FF);
                    CH_N: put_byte(BY_LF);
                    CH_R: put_byte(BY_CR);
                    CH_T: put_byte(BY_TAB);
                    CH_V: put_byte(BY_VT);
                    CH_X: dec_mode = MODE_HEX0;
                    default: begin
                        if (is_octal_digit(c)) begin
                            dec_held = {6'd0, c[2:0]};
                            dec_mode = MODE_OCT1;
                        end else begin
                            put_byte(c);
                        end
                    end
                endcase
            end
            MODE_OCT1: begin
                if (is_octal_digit(c)) begin
                    dec_held = {dec_held[5:0], c[2:0]};
                    dec_mode = MODE_OCT2;
                end else begin
                    put_byte(dec_held[7:0]);
                    take_plain(c);
                end
            end
            MODE_OCT2: begin
                if (is_octal_digit(c)) begin
                    oct = {dec_held, 3'b000} + c[2:0];
                    put_byte((oct > 12'd255) ? 8'hFF : oct[7:0]);
                    dec_mode = MODE_PLAIN;
                end else begin
                    put_byte(dec_held[7:0]);
                    take_plain(c);
                end
            end
            MODE_HEX0: begin
                if (is_hex_digit(c)) begin
                    dec_held = {1'b0, c};
                    dec_mode = MODE_HEX1;
                end else begin
                    put_byte(CH_X);
                    take_plain(c);
                end
            end
            MODE_HEX1: begin
                if (is_hex_digit(c)) begin
                    put_byte({nibble_of(dec_held[7:0]), nibble_of(c)});
                    dec_mode = MODE_PLAIN;
                end else begin
                    put_byte(CH_X);
                    put_byte(dec_held[7:0]);
                    take_plain(c);
                end
            end
            default: take_plain(c);
        endcase
    endfunction

    // Last character: flush a pending escape, tag the closing result, clear state
    function automatic void close_string();
        case (dec_mode)
            MODE_OCT1, MODE_OCT2: put_byte(dec_held[7:0]);
            MODE_HEX0: put_byte(CH_X);
            MODE_HEX1: begin
                put_byte(CH_X);
                put_byte(dec_held[7:0]);
            end
            default: ;
        endcase
        if (step_n == 0) begin
            step_res[0] = '0;
            step_n = 1;
        end
        step_res[step_n-1].end_of_string  = 1'b1;
        step_res[step_n-1].decoded_length = dec_count;
        dec_mode  = MODE_PLAIN;
        dec_held  = '0;
        dec_count = '0;
    endfunction

    // Send one item, with random idle cycles ahead of it
    task automatic send_char(input logic [7:0] ch, input logic fin);
        while (!no_idle && ($urandom_range(99) < IDLE_PCT)) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_in_char  <= ch;
        s_is_final <= fin;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        step_n = 0;
        decode_char(ch);
        if (fin) begin
            close_string();
        end
        for (int i = 0; i < step_n; i++) begin
            expected_bytes.push_back(step_res[i]);
        end
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) begin
            send_char(txt[i], i == txt.len() - 1);
        end
    endtask

    task automatic test_plain_bytes();
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h41, 1'b1);
    endtask

    task automatic test_control_escapes();
        send_text("\\a\\b\\e\\f\\n\\r\\t\\v");
    endtask

    // Overflowing three digits, two digits cut short, one digit flushed at the end
    task automatic test_octal_escapes();
        send_text("\\777\\12q\\5");
        send_text("\\12");
    endtask

    // Full hex, broken with and without a digit, unknown escape, pending \x flushed
    task automatic test_hex_escapes();
        send_text("\\xFf\\x4z\\xg\\q\\x");
        send_text("\\xA");
    endtask

    // Lone trailing backslash: dropped, and alone it gives an empty end
    task automatic test_end_flush();
        send_text("\\");
        send_text("ab\\");
    endtask

    // A long plain string sent back to back with no idling on either side
    task automatic test_long_string();
        logic [7:0] c;
        no_idle = 1'b1;
        for (int i = 0; i < LONG_ITEMS - 1; i++) begin
            c = 8'($urandom_range(255));
            send_char((c == CH_BSL) ? 8'h00 : c, 1'b0);
        end
        send_char(8'h5A, 1'b1);
        no_idle = 1'b0;
    endtask

    // Random strings mixing well-formed escapes, broken escapes and random bytes
    task automatic test_random_strings();
        logic [7:0] letters [0:7];
        logic [7:0] hexchars [0:21];
        logic [7:0] text [$];
        int         sent;
        int         ntok;
        letters = '{CH_A, CH_B, CH_E, CH_F, CH_N, CH_R, CH_T, CH_V};
        for (int i = 0; i < 10; i++) hexchars[i] = DIG_0 + 8'(i);
        for (int i = 0; i < 6; i++) begin
            hexchars[10 + i] = UPP_A + 8'(i);
            hexchars[16 + i] = UPP_A + 8'h20 + 8'(i);
        end
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            text.delete();
            ntok = $urandom_range(1, 8);
            for (int t = 0; t < ntok; t++) begin
                case ($urandom_range(9))
                    0, 1, 2: text.push_back(8'($urandom_range(255)));
                    3: begin
                        text.push_back(CH_BSL);
                        text.push_back(letters[$urandom_range(7)]);
                    end
                    4: begin
                        text.push_back(CH_BSL);
                        repeat ($urandom_range(1, 3)) text.push_back(DIG_0 + 8'($urandom_range(7)));
                    end
                    5: begin
                        text.push_back(CH_BSL);
                        text.push_back(CH_X);
                        text.push_back(hexchars[$urandom_range(21)]);
                        text.push_back(hexchars[$urandom_range(21)]);
                    end
                    6: begin
                        text.push_back(CH_BSL);
                        text.push_back(CH_X);
                        if ($urandom_range(1)) text.push_back(hexchars[$urandom_range(21)]);
                        text.push_back(8'($urandom_range(255)));
                    end
                    7: begin
                        text.push_back(CH_BSL);
                        text.push_back(8'($urandom_range(255)));
                    end
                    8: text.push_back(CH_BSL);
                    default: text.push_back(hexchars[$urandom_range(21)]);
                endcase
            end
            for (int i = 0; i < text.size(); i++) begin
                send_char(text[i], i == text.size() - 1);
            end
            sent += text.size();
        end
    endtask

    // Result side backpressure
    always @(posedge aclk) begin
        m_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    task automatic report_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // Compare every accepted result with the oldest expected one
    always @(posedge aclk) begin : result_check
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected result: expected none, %s %0h valid %0b end %0b len %0d",
                         $time, "actual byte", m_out_byte, m_byte_valid, m_end_of_string,
                         m_decoded_length);
                fail_count++;
            end else begin
                want = expected_bytes.pop_front();
                report_field("out_byte", want.out_byte, m_out_byte);
                report_field("byte_valid", want.byte_valid, m_byte_valid);
                report_field("end_of_string", want.end_of_string, m_end_of_string);
                report_field("decoded_length", want.decoded_length, m_decoded_length);
            end
        end
    end

    // Watchdog: too long without any item moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, %0d results still expected", $time, expected_bytes.size());
            $display("Simulation FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_plain_bytes();
        test_control_escapes();
        test_octal_escapes();
        test_hex_escapes();
        test_end_flush();
        test_long_string();
        test_random_strings();
        s_valid <= 1'b0;
        while (expected_bytes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+hdl
hdl/esd_pkg.sv
hdl/escaped_string_decoder.sv
sim/escaped_string_decoder_tb.sv
